// File: sv/cbpiir_pkg.sv
// shared types, constants and fixed-point helpers of the cascaded band-pass equalizer
// no dependencies

package cbpiir_pkg;

   localparam int DEF_CHANNELS = 2;
   localparam int DEF_STAGES   = 16;

   typedef enum logic [1:0] {
      COEF_A1   = 2'd0,
      COEF_A2   = 2'd1,
      COEF_GAIN = 2'd2
   } coef_sel_type;

   typedef enum logic {
      REG_NUM_STAGES = 1'b0,
      REG_BYPASS     = 1'b1
   } reg_idx_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_COEF   = 1'b1
   } cmd_type;

   // token travelling along the chain with its sample
   typedef struct packed {
      logic valid;
      logic ch;
      logic en;
   } tok_type;

   // coefficient write broadcast to all cells
   typedef struct packed {
      logic               we;
      logic [3:0]         stage;
      logic [1:0]         sel;
      logic signed [23:0] value;
   } cw_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q8.24 x Q4.20 rounded half up to Q12.24
   function automatic logic signed [35:0] rmul(input logic signed [31:0] v,
                                               input logic signed [23:0] c);
      logic signed [55:0] p;
      p = 56'(v) * 56'(c);
      p = p + 56'sd524288;
      return p[55:20];
   endfunction

endpackage

// File: sv/cbpiir_cell.sv
// one second-order band-pass peaking stage of the chain, with its own coefficients
// and per-channel state pair; depends on cbpiir_pkg

module cbpiir_cell import cbpiir_pkg::*; #(
   parameter int IDX      = 0,
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [4:0]         num_stages,
   input  cw_type             cw,
   input  tok_type            tok_i,
   input  logic signed [31:0] x_i,
   output tok_type            tok_o,
   output logic signed [31:0] x_o
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic signed [23:0] a1_ff, a2_ff, g_ff;
   logic signed [31:0] s0_ff [CHANNELS];
   logic signed [31:0] s1_ff [CHANNELS];

   tok_type            tok0_ff, tok1_ff, tok2_ff;
   logic               act0_ff, act1_ff;
   logic signed [31:0] x0_ff, x1_ff, x2_ff;
   logic signed [31:0] v_ff;
   logic signed [35:0] p1_ff, p2_ff, pg_ff;

   logic [CH_W-1:0]    ci, c1;
   logic               act_in;
   logic signed [31:0] v_in;

   assign ci     = CH_W'(tok_i.ch);
   assign c1     = CH_W'(tok1_ff.ch);
   assign act_in = tok_i.en && (32'(IDX) < 32'(num_stages));
   assign v_in   = act_in ? sat32(40'(x_i) + 40'(s0_ff[ci])) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff   <= '0;
         a2_ff   <= '0;
         g_ff    <= '0;
         tok0_ff <= '0;
         tok1_ff <= '0;
         tok2_ff <= '0;
         act0_ff <= 1'b0;
         act1_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            s0_ff[c] <= '0;
            s1_ff[c] <= '0;
         end
      end else begin
         if (cw.we && (32'(cw.stage) == IDX)) begin
            case (cw.sel)
               COEF_A1:   a1_ff <= cw.value;
               COEF_A2:   a2_ff <= cw.value;
               COEF_GAIN: g_ff  <= cw.value;
               default:   ;
            endcase
         end
         tok0_ff <= tok_i;
         tok1_ff <= tok0_ff;
         tok2_ff <= tok1_ff;
         act0_ff <= tok_i.valid && act_in;
         act1_ff <= act0_ff;
         if (act1_ff) begin
            s0_ff[c1] <= sat32(40'(s1_ff[c1]) - 40'(p1_ff));
            s1_ff[c1] <= sat32(-40'(x1_ff) - 40'(p2_ff));
         end
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      x0_ff <= x_i;
      v_ff  <= v_in;
      p1_ff <= rmul(v_ff, a1_ff);
      p2_ff <= rmul(v_ff, a2_ff);
      pg_ff <= act0_ff ? rmul(v_ff, g_ff) : '0;
      x1_ff <= x0_ff;
      x2_ff <= sat32(40'(x1_ff) + 40'(pg_ff));
   end

   assign tok_o = tok2_ff;
   assign x_o   = x2_ff;

endmodule

// File: sv/cascaded_bandpass_peaking_iir.sv
// Per-channel cascaded band-pass peaking equalizer: a chain of stage cells,
// each holding its coefficients and per-channel state pair.
//
// Usage:
//   req_ channel: cmd 0 carries an audio sample (Q1.23) for a channel, cmd 1
//   writes one coefficient (a1, a2 or gain, Q4.20) of one stage. A transaction
//   happens when req_valid is high and req_stall low.
//   rsp_ channel: one result per audio sample, none per coefficient write;
//   taken when rsp_valid is high and rsp_stall low.
//   csr_ port: index 0 num_stages, index 1 bypass; csr_ready is always high.
// Flow: a sample walks the whole chain, through the token and payload
// registers of each cell, and the rounded, clipped result is registered
// before rsp_valid rises; one sample is in flight at a time, so a new
// sample is taken only after the previous result has been taken. After a
// coefficient write the next transaction may follow directly.
// Reset (synchronous, active high) clears coefficients and delay state,
// sets num_stages 0 and bypass 1. While a result waits under rsp_stall it
// holds, and req_stall stays high until it is taken.

module cascaded_bandpass_peaking_iir import cbpiir_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS,
   parameter int STAGES   = DEF_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic               req_channel,
   input  logic signed [23:0] req_sample,
   input  logic [3:0]         req_coef_stage,
   input  logic [1:0]         req_coef_select,
   input  logic signed [23:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_out_sample,
   output logic               rsp_out_channel,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [4:0]         csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         num_stages_ff;
   logic               bypass_ff;
   logic               accept;
   cw_type             cw;
   tok_type            tok [STAGES+1];
   logic signed [31:0] xs  [STAGES+1];
   logic signed [23:0] out_sample_ff;
   logic               out_channel_ff, sat_ff;
   logic signed [32:0] rnd;
   logic signed [31:0] y;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign cw.we    = accept && (req_cmd == CMD_COEF);
   assign cw.stage = req_coef_stage;
   assign cw.sel   = req_coef_select;
   assign cw.value = req_coef_value;

   assign tok[0].valid = accept && (req_cmd == CMD_SAMPLE);
   assign tok[0].ch    = req_channel;
   assign tok[0].en    = !bypass_ff && (32'(req_channel) < CHANNELS);
   assign xs[0]        = {{7{req_sample[23]}}, req_sample, 1'b0};

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      cbpiir_cell #(
         .IDX      (i),
         .CHANNELS (CHANNELS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .num_stages (num_stages_ff),
         .cw         (cw),
         .tok_i      (tok[i]),
         .x_i        (xs[i]),
         .tok_o      (tok[i+1]),
         .x_o        (xs[i+1])
      );
   end

   // back to Q1.23 with rounding
   assign rnd = 33'(xs[STAGES]) + 33'sd1;
   assign y   = rnd[32:1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (tok[0].valid) state_in = ST_BUSY;
         ST_BUSY: if (tok[STAGES].valid) state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_stages_ff <= '0;
         bypass_ff     <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_NUM_STAGES: num_stages_ff <= csr_wdata;
               REG_BYPASS:     bypass_ff     <= csr_wdata[0];
               default:        ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok[STAGES].valid) begin
         out_channel_ff <= tok[STAGES].ch;
         if (y > 32'sd8388607) begin
            out_sample_ff <= 24'sh7fffff;
            sat_ff        <= 1'b1;
         end else if (y < -32'sd8388608) begin
            out_sample_ff <= 24'sh800000;
            sat_ff        <= 1'b1;
         end else begin
            out_sample_ff <= y[23:0];
            sat_ff        <= 1'b0;
         end
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_out_sample  = out_sample_ff;
   assign rsp_out_channel = out_channel_ff;
   assign rsp_saturated   = sat_ff;

   a_tail_only_busy: assert property (@(posedge clock) disable iff (reset)
      tok[STAGES].valid |-> state_ff == ST_BUSY)
      else $error("sample left chain while not busy");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      tok[0].valid |=> state_ff == ST_BUSY)
      else $error("accepted sample did not start chain");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_sample == 24'sh7fffff || rsp_out_sample == 24'sh800000)
      else $error("saturated flag without clipped value");

endmodule

// File: tb/tb_cascaded_bandpass_peaking_iir.sv
// self-checking testbench for the cascaded band-pass peaking equalizer
// depends on cbpiir_pkg and cascaded_bandpass_peaking_iir; predicts each result in place
`timescale 1ns / 1ps

module tb_cascaded_bandpass_peaking_iir import cbpiir_pkg::*;;

   localparam int NCH = 2;
   localparam int NSTG = 16;
   localparam int SETTLE = 3 * NSTG + 10;

   typedef struct packed {
      logic signed [23:0] smp;
      logic               ch;
      logic               sat;
   } eq_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = 1'b0;
   logic               req_channel = 1'b0;
   logic signed [23:0] req_sample = '0;
   logic [3:0]         req_coef_stage = '0;
   logic [1:0]         req_coef_select = '0;
   logic signed [23:0] req_coef_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_out_sample;
   logic               rsp_out_channel;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic [4:0]         csr_wdata = '0;

   // predictor state
   logic signed [23:0] coefs [NSTG*3];
   logic signed [31:0] dstate [NCH*NSTG*2];
   logic [4:0]         stages_set;
   logic               bypass_set;

   eq_out_type filtered_q [$];
   int errors = 0;
   bit no_stall = 1'b0;

   cascaded_bandpass_peaking_iir dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] qprod(input logic signed [31:0] v,
                                                input logic signed [23:0] c);
      logic signed [63:0] p;
      p = 64'(v) * 64'(c) + 64'sd524288;
      return p >>> 20;
   endfunction

   task automatic predict_item(input logic cmd, input logic ch, input logic signed [23:0] smp,
                               input logic [3:0] stg, input logic [1:0] sel,
                               input logic signed [23:0] cv);
      int n;
      int b;
      logic signed [31:0] x;
      logic signed [31:0] v;
      logic signed [63:0] y;
      eq_out_type r;
      if (cmd == CMD_COEF) begin
         if (sel != 2'd3) coefs[stg*3 + sel] = cv;
         return;
      end
      r.ch = ch;
      r.sat = 1'b0;
      r.smp = smp;
      n = (stages_set > NSTG) ? NSTG : stages_set;
      if (!bypass_set && n != 0) begin
         x = 32'(smp) <<< 1;
         for (int f = 0; f < n; f++) begin
            b = (ch * NSTG + f) * 2;
            v = clip32(64'(x) + 64'(dstate[b]));
            dstate[b] = clip32(64'(dstate[b+1]) - qprod(v, coefs[f*3 + COEF_A1]));
            dstate[b+1] = clip32(-64'(x) - qprod(v, coefs[f*3 + COEF_A2]));
            x = clip32(64'(x) + qprod(v, coefs[f*3 + COEF_GAIN]));
         end
         y = (64'(x) + 1) >>> 1;
         if (y > 64'sd8388607) begin
            y = 64'sd8388607;
            r.sat = 1'b1;
         end else if (y < -64'sd8388608) begin
            y = -64'sd8388608;
            r.sat = 1'b1;
         end
         r.smp = y[23:0];
      end
      filtered_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sends one transaction after a random gap
   task automatic send_item(input logic cmd, input logic ch, input logic signed [23:0] smp,
                            input logic [3:0] stg, input logic [1:0] sel,
                            input logic signed [23:0] cv);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_channel <= ch;
      req_sample <= smp;
      req_coef_stage <= stg;
      req_coef_select <= sel;
      req_coef_value <= cv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(cmd, ch, smp, stg, sel, cv);
   endtask

   task automatic send_sample(input logic ch, input logic signed [23:0] smp);
      send_item(CMD_SAMPLE, ch, smp, 4'($urandom), 2'($urandom), 24'($urandom));
   endtask

   task automatic send_coef(input logic [3:0] stg, input logic [1:0] sel,
                            input logic signed [23:0] cv);
      send_item(CMD_COEF, 1'($urandom), 24'($urandom), stg, sel, cv);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [4:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_NUM_STAGES) stages_set = val;
      else bypass_set = val[0];
   endtask

   // checker with random receiver stalls
   initial begin
      eq_out_type e;
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_out_sample), 32'd0);
            end else begin
               e = filtered_q.pop_front();
               if (rsp_out_sample !== e.smp)
                  report_mismatch("out_sample", 32'(rsp_out_sample), 32'(e.smp));
               if (rsp_out_channel !== e.ch)
                  report_mismatch("out_channel", 32'(rsp_out_channel), 32'(e.ch));
               if (rsp_saturated !== e.sat)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(e.sat));
            end
            hold = no_stall ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) hold = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_bypass();
      send_sample(1'b0, 24'sh7fffff);
      send_sample(1'b1, 24'sh800000);
      write_reg(REG_NUM_STAGES, 5'd4);
      send_sample(1'b0, 24'sh123456);
      write_reg(REG_BYPASS, 5'd0);
      write_reg(REG_NUM_STAGES, 5'd0);
      send_sample(1'b1, 24'sh654321);
   endtask

   task automatic test_directed();
      // extreme coefficients, bad address ignored
      send_coef(4'd0, COEF_A1, 24'sh7fffff);
      send_coef(4'd0, COEF_A2, 24'sh800000);
      send_coef(4'd0, COEF_GAIN, 24'sh7fffff);
      send_coef(4'd15, COEF_GAIN, 24'sh800000);
      send_coef(4'd1, 2'd3, 24'sh7fffff);
      write_reg(REG_NUM_STAGES, 5'd31);
      send_sample(1'b0, 24'sh7fffff);
      send_sample(1'b0, 24'sh800000);
      send_sample(1'b1, 24'sh7fffff);
      send_sample(1'b1, 24'sh000000);
      send_sample(1'b0, 24'sh7fffff);
      write_reg(REG_NUM_STAGES, 5'd16);
      send_sample(1'b1, 24'sh800000);
      send_sample(1'b0, 24'sh000001);
      write_reg(REG_NUM_STAGES, 5'd17);
      send_sample(1'b0, 24'shffffff);
   endtask

   task automatic test_random(input int count, input int max_stg);
      int k;
      int t;
      for (k = 0; k < count; k++) begin
         t = $urandom_range(0, 9);
         if (t == 0 && $urandom_range(0, 1)) begin
            send_item(CMD_COEF, 1'($urandom), 24'($urandom), 4'($urandom), 2'($urandom),
                      24'($urandom));
         end else if (t == 0) begin
            // stable-ish small coefficients so the state does not just pin
            send_coef(4'($urandom_range(0, max_stg)), 2'($urandom_range(0, 2)),
                      24'($signed($urandom_range(0, 2097152)) - 1048576));
         end else if (t == 1) begin
            send_sample(1'($urandom), 24'($urandom));
         end else begin
            send_sample(1'($urandom), 24'($signed($urandom_range(0, 1048576)) - 524288));
         end
      end
   endtask

   task automatic test_pause();
      drain();
      no_stall = 1'b1;
      test_random(40, 3);
      no_stall = 1'b0;
   endtask

   initial begin
      foreach (coefs[i]) coefs[i] = '0;
      foreach (dstate[i]) dstate[i] = '0;
      stages_set = '0;
      bypass_set = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_directed();
      write_reg(REG_NUM_STAGES, 5'd2);
      test_random(500, 1);
      write_reg(REG_NUM_STAGES, 5'd5);
      test_random(500, 4);
      test_pause();
      write_reg(REG_NUM_STAGES, 5'd16);
      test_random(400, 15);
      write_reg(REG_BYPASS, 5'd1);
      test_random(150, 15);
      write_reg(REG_BYPASS, 5'd0);
      write_reg(REG_NUM_STAGES, 5'd31);
      test_random(230, 15);
      drain();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule
